>>> rtl/core/assert_macros.svh
// Assertion macros shared by the downmix RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define PDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define PDM_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);

`endif

>>> rtl/core/pdm_pkg.sv
// Shared types, constants and codes of the stereo downmix block.
package pdm_pkg;

  localparam int unsigned MaxChannels = 8;
  localparam int unsigned SampleW     = 32;
  localparam int unsigned NormW       = 32;
  localparam int unsigned OutW        = 24;
  localparam int unsigned MixW        = 35;
  localparam int unsigned GainW       = 16;
  localparam int unsigned AddrW       = 4;
  localparam int unsigned DataW       = 32;
  localparam int unsigned NumSides    = 2;
  localparam int unsigned PipeLatency = 9;

  // Reciprocals round(2^62 / (2^(n-1)-1)), split into two partial products.
  localparam int unsigned RcW     = 56;
  localparam int unsigned RcSplit = 28;
  localparam logic [RcW-1:0] Rc8  = RcW'(((64'd1 << 62) + 64'd63) / 64'd127);
  localparam logic [RcW-1:0] Rc16 = RcW'(((64'd1 << 62) + 64'd16383) / 64'd32767);
  localparam logic [RcW-1:0] Rc24 = RcW'(((64'd1 << 62) + 64'd4194303) / 64'd8388607);
  localparam logic [RcW-1:0] Rc32 = RcW'(((64'd1 << 62) + 64'd1073741823) / 64'd2147483647);

  // Mix coefficients, Q.30.
  localparam logic [29:0] SurrQ30  = 30'd759250125;
  localparam logic [29:0] Attn4Q30 = 30'd715827883;
  localparam logic [29:0] Attn5Q30 = 30'd486492921;

  localparam int OutMax = 8388607;
  localparam int OutMin = -8388608;

  // Sample format codes.
  localparam logic [1:0] FmtW8  = 2'd0;
  localparam logic [1:0] FmtW16 = 2'd1;
  localparam logic [1:0] FmtW24 = 2'd2;
  localparam logic [1:0] FmtW32 = 2'd3;

  // Channel layout codes.
  localparam logic [3:0] LayoutMono   = 4'd0;
  localparam logic [3:0] LayoutStereo = 4'd1;
  localparam logic [3:0] LayoutQuad   = 4'd2;
  localparam logic [3:0] Layout21     = 4'd3;
  localparam logic [3:0] Layout31     = 4'd4;
  localparam logic [3:0] Layout41     = 4'd5;
  localparam logic [3:0] LayoutLcrs   = 4'd6;
  localparam logic [3:0] Layout51     = 4'd7;
  localparam logic [3:0] Layout71     = 4'd8;
  localparam logic [3:0] Layout71Surr = 4'd9;

  // Register indexes.
  localparam logic [1:0] RegSampleFormat  = 2'd0;
  localparam logic [1:0] RegChannelLayout = 2'd1;
  localparam logic [1:0] RegGain          = 2'd2;

  localparam logic [1:0]       SampleFormatRst  = FmtW16;
  localparam logic [3:0]       ChannelLayoutRst = LayoutStereo;
  localparam logic [GainW-1:0] GainRst          = 16'd4096;

  typedef enum logic [1:0] {
    AttnNone,
    AttnQuad,
    AttnFull
  } pdm_attn_e;

  typedef struct packed {
    logic signed [SampleW-1:0] ch0;
    logic signed [SampleW-1:0] ch1;
    logic signed [SampleW-1:0] ch2;
    logic signed [SampleW-1:0] ch3;
    logic signed [SampleW-1:0] ch4;
    logic signed [SampleW-1:0] ch5;
    logic signed [SampleW-1:0] ch6;
    logic signed [SampleW-1:0] ch7;
  } pdm_in_t;

  typedef struct packed {
    logic signed [OutW-1:0] out_left;
    logic signed [OutW-1:0] out_right;
  } pdm_out_t;

  typedef struct packed {
    logic [1:0]       sample_format;
    logic [3:0]       channel_layout;
    logic [GainW-1:0] gain;
  } pdm_cfg_t;

endpackage

>>> rtl/core/pdm_regs.sv
// Configuration register file with an APB-style access port.
`include "assert_macros.svh"

module pdm_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [pdm_pkg::AddrW-1:0]   paddr_i,
  input  logic [pdm_pkg::DataW-1:0]   pwdata_i,
  output logic [pdm_pkg::DataW-1:0]   prdata_o,
  output pdm_pkg::pdm_cfg_t           cfg_o
);
  import pdm_pkg::*;

  logic     wr_en;
  pdm_cfg_t cfg_q;

  assign wr_en = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_format  <= SampleFormatRst;
      cfg_q.channel_layout <= ChannelLayoutRst;
      cfg_q.gain           <= GainRst;
    end else if (wr_en) begin
      case (paddr_i[AddrW-1:2])
        RegSampleFormat:  cfg_q.sample_format  <= pwdata_i[1:0];
        RegChannelLayout: cfg_q.channel_layout <= pwdata_i[3:0];
        RegGain:          cfg_q.gain           <= pwdata_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr_i[AddrW-1:2])
      RegSampleFormat:  prdata_o = DataW'(cfg_q.sample_format);
      RegChannelLayout: prdata_o = DataW'(cfg_q.channel_layout);
      RegGain:          prdata_o = DataW'(cfg_q.gain);
      default:          prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

  `PDM_ASSERT_NEVER(CfgHoldsWithoutWrite, $past(!wr_en) && !$stable(cfg_q), "config changed without a write")

endmodule

>>> rtl/core/pdm_norm.sv
// Normalize stages: sign-extend each channel and scale it by the format reciprocal.
`include "assert_macros.svh"

module pdm_norm (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 valid_i,
  input  pdm_pkg::pdm_in_t                                     word_i,
  input  logic [1:0]                                           sample_format_i,
  output logic                                                 valid_o,
  output logic [pdm_pkg::MaxChannels-1:0][pdm_pkg::NormW-1:0]  norm_o
);
  import pdm_pkg::*;

  localparam int unsigned ProdW     = SampleW + RcSplit + 1;
  localparam int unsigned FullW     = 66;
  localparam int unsigned NormShift = 32;
  localparam logic signed [FullW-1:0] NormRnd = FullW'(64'h0000_0000_8000_0000);

  logic [SampleW-1:0]        raw    [MaxChannels];
  logic [SampleW-1:0]        x_d    [MaxChannels];
  logic signed [SampleW-1:0] x_q    [MaxChannels];
  logic [RcW-1:0]            rc;
  logic signed [ProdW-1:0]   pl_d   [MaxChannels];
  logic signed [ProdW-1:0]   ph_d   [MaxChannels];
  logic signed [ProdW-1:0]   pl_q   [MaxChannels];
  logic signed [ProdW-1:0]   ph_q   [MaxChannels];
  logic signed [FullW-1:0]   full   [MaxChannels];
  logic [NormW-1:0]          norm_d [MaxChannels];
  logic [NormW-1:0]          norm_q [MaxChannels];
  logic                      v1_q, v2_q, v3_q;

  assign raw[0] = word_i.ch0;
  assign raw[1] = word_i.ch1;
  assign raw[2] = word_i.ch2;
  assign raw[3] = word_i.ch3;
  assign raw[4] = word_i.ch4;
  assign raw[5] = word_i.ch5;
  assign raw[6] = word_i.ch6;
  assign raw[7] = word_i.ch7;

  // Drop bits above the sample width, then sign-extend.
  always_comb begin
    for (int i = 0; i < MaxChannels; i++) begin
      case (sample_format_i)
        FmtW8:   x_d[i] = {{24{raw[i][7]}}, raw[i][7:0]};
        FmtW16:  x_d[i] = {{16{raw[i][15]}}, raw[i][15:0]};
        FmtW24:  x_d[i] = {{8{raw[i][23]}}, raw[i][23:0]};
        default: x_d[i] = raw[i];
      endcase
    end
  end

  always_comb begin
    case (sample_format_i)
      FmtW8:   rc = Rc8;
      FmtW16:  rc = Rc16;
      FmtW24:  rc = Rc24;
      default: rc = Rc32;
    endcase
  end

  always_comb begin
    for (int i = 0; i < MaxChannels; i++) begin
      pl_d[i] = x_q[i] * $signed({1'b0, rc[RcSplit-1:0]});
      ph_d[i] = x_q[i] * $signed({1'b0, rc[RcW-1:RcSplit]});
    end
  end

  // Join the partial products and round half up to Q2.30.
  always_comb begin
    for (int i = 0; i < MaxChannels; i++) begin
      full[i]   = (FullW'(ph_q[i]) <<< RcSplit) + FullW'(pl_q[i]) + NormRnd;
      norm_d[i] = full[i][NormShift +: NormW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxChannels; i++) begin
      x_q[i]    <= $signed(x_d[i]);
      pl_q[i]   <= pl_d[i];
      ph_q[i]   <= ph_d[i];
      norm_q[i] <= norm_d[i];
    end
  end

  always_comb begin
    for (int i = 0; i < MaxChannels; i++) begin
      norm_o[i] = norm_q[i];
    end
  end

  assign valid_o = v3_q;

  `PDM_ASSERT(NormKeepsSign, v3_q |-> ((norm_q[0][NormW-1] == $past(x_q[0][SampleW-1], 2)) && ((norm_q[0] == '0) == ($past(x_q[0], 2) == '0))), "normalized sample lost its sign")

endmodule

>>> rtl/core/pdm_mix.sv
// Mix stages: fold the normalized channels to two sides and attenuate.
module pdm_mix (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                valid_i,
  input  logic [pdm_pkg::MaxChannels-1:0][pdm_pkg::NormW-1:0] norm_i,
  input  logic [3:0]                                          channel_layout_i,
  output logic                                                valid_o,
  output logic [pdm_pkg::NumSides-1:0][pdm_pkg::MixW-1:0]     mixed_o
);
  import pdm_pkg::*;

  localparam int unsigned RearW = NormW + 1;
  localparam int unsigned ProdW = RearW + 31;
  localparam int unsigned SumW  = 66;
  localparam int unsigned AttW  = MixW + 31;
  localparam logic signed [SumW-1:0] MixRnd = SumW'(64'h0000_0000_4000_0000);
  localparam logic signed [AttW-1:0] AttRnd = AttW'(64'h0000_0000_2000_0000);

  logic signed [NormW-1:0] f_d    [NumSides];
  logic signed [NormW-1:0] c_d    [NumSides];
  logic signed [RearW-1:0] r_d    [NumSides];
  pdm_attn_e               attn_d;
  logic signed [ProdW-1:0] prod_d [NumSides];

  logic signed [NormW-1:0] f_q    [NumSides];
  logic signed [NormW-1:0] c_q    [NumSides];
  logic signed [ProdW-1:0] prod_q [NumSides];
  pdm_attn_e               attn4_q;

  logic signed [SumW-1:0]  sum    [NumSides];
  logic signed [MixW-1:0]  m_q    [NumSides];
  pdm_attn_e               attn5_q;

  logic [29:0]             coef;
  logic signed [AttW-1:0]  ap_d   [NumSides];
  logic signed [AttW-1:0]  ap_q   [NumSides];
  logic signed [MixW-1:0]  m6_q   [NumSides];
  pdm_attn_e               attn6_q;

  logic signed [AttW-1:0]  rnd    [NumSides];
  logic signed [MixW-1:0]  x_d    [NumSides];
  logic signed [MixW-1:0]  x_q    [NumSides];

  logic                    v4_q, v5_q, v6_q, v7_q;

  // Route channels per layout: front, center weight 0.5, rear sum weight 0.7071.
  always_comb begin
    f_d[0] = $signed(norm_i[0]);
    f_d[1] = $signed(norm_i[1]);
    c_d[0] = '0;
    c_d[1] = '0;
    r_d[0] = '0;
    r_d[1] = '0;
    attn_d = AttnNone;
    case (channel_layout_i)
      LayoutMono: begin
        f_d[1] = $signed(norm_i[0]);
      end
      LayoutQuad: begin
        c_d[0] = $signed(norm_i[2]);
        c_d[1] = $signed(norm_i[3]);
        attn_d = AttnQuad;
      end
      Layout41: begin
        c_d[0] = $signed(norm_i[3]);
        c_d[1] = $signed(norm_i[4]);
        attn_d = AttnQuad;
      end
      Layout51, Layout71: begin
        c_d[0] = $signed(norm_i[2]);
        c_d[1] = $signed(norm_i[2]);
        r_d[0] = {$signed(norm_i[4]), 1'b0};
        r_d[1] = {$signed(norm_i[5]), 1'b0};
        attn_d = AttnFull;
      end
      Layout71Surr: begin
        c_d[0] = $signed(norm_i[2]);
        c_d[1] = $signed(norm_i[2]);
        r_d[0] = RearW'($signed(norm_i[4])) + RearW'($signed(norm_i[6]));
        r_d[1] = RearW'($signed(norm_i[5])) + RearW'($signed(norm_i[7]));
        attn_d = AttnFull;
      end
      default: ;
    endcase
    for (int k = 0; k < NumSides; k++) begin
      prod_d[k] = r_d[k] * $signed({1'b0, SurrQ30});
    end
  end

  // Sum at Q.61 and round to Q.30.
  always_comb begin
    for (int k = 0; k < NumSides; k++) begin
      sum[k] = (SumW'(f_q[k]) <<< 31) + (SumW'(c_q[k]) <<< 30) + SumW'(prod_q[k]) + MixRnd;
    end
  end

  always_comb begin
    case (attn5_q)
      AttnQuad: coef = Attn4Q30;
      AttnFull: coef = Attn5Q30;
      default:  coef = '0;
    endcase
    for (int k = 0; k < NumSides; k++) begin
      ap_d[k] = m_q[k] * $signed({1'b0, coef});
    end
  end

  always_comb begin
    for (int k = 0; k < NumSides; k++) begin
      rnd[k] = ap_q[k] + AttRnd;
      x_d[k] = (attn6_q == AttnNone) ? m6_q[k] : rnd[k][30 +: MixW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v4_q <= valid_i;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    attn4_q <= attn_d;
    attn5_q <= attn4_q;
    attn6_q <= attn5_q;
    for (int k = 0; k < NumSides; k++) begin
      f_q[k]    <= f_d[k];
      c_q[k]    <= c_d[k];
      prod_q[k] <= prod_d[k];
      m_q[k]    <= sum[k][31 +: MixW];
      ap_q[k]   <= ap_d[k];
      m6_q[k]   <= m_q[k];
      x_q[k]    <= x_d[k];
    end
  end

  always_comb begin
    for (int k = 0; k < NumSides; k++) begin
      mixed_o[k] = x_q[k];
    end
  end

  assign valid_o = v7_q;

endmodule

>>> rtl/core/pdm_gain.sv
// Gain stages: apply the Q4.12 volume, round and saturate to Q1.23.
module pdm_gain (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            valid_i,
  input  logic [pdm_pkg::NumSides-1:0][pdm_pkg::MixW-1:0] mixed_i,
  input  logic [pdm_pkg::GainW-1:0]                       gain_i,
  output logic                                            valid_o,
  output pdm_pkg::pdm_out_t                               result_o
);
  import pdm_pkg::*;

  localparam int unsigned GpW = MixW + GainW + 1;
  localparam int unsigned YW  = GpW - 19;
  localparam logic signed [GpW-1:0] GainRnd = GpW'(64'h0000_0000_0004_0000);
  localparam logic signed [YW-1:0]  YMax    = YW'(OutMax);
  localparam logic signed [YW-1:0]  YMin    = YW'(OutMin);

  logic signed [GpW-1:0]  gp_d  [NumSides];
  logic signed [GpW-1:0]  gp_q  [NumSides];
  logic signed [GpW-1:0]  rnd   [NumSides];
  logic signed [YW-1:0]   y     [NumSides];
  logic signed [OutW-1:0] out_d [NumSides];
  logic signed [OutW-1:0] out_q [NumSides];
  logic                   v8_q, v9_q;

  always_comb begin
    for (int k = 0; k < NumSides; k++) begin
      gp_d[k] = $signed(mixed_i[k]) * $signed({1'b0, gain_i});
    end
  end

  // Round half up, then clamp to the 24-bit range.
  always_comb begin
    for (int k = 0; k < NumSides; k++) begin
      rnd[k] = gp_q[k] + GainRnd;
      y[k]   = rnd[k][19 +: YW];
      if (y[k] > YMax) begin
        out_d[k] = YMax[OutW-1:0];
      end else if (y[k] < YMin) begin
        out_d[k] = YMin[OutW-1:0];
      end else begin
        out_d[k] = y[k][OutW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else begin
      v8_q <= valid_i;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumSides; k++) begin
      gp_q[k]  <= gp_d[k];
      out_q[k] <= out_d[k];
    end
  end

  assign valid_o            = v9_q;
  assign result_o.out_left  = out_q[0];
  assign result_o.out_right = out_q[1];

endmodule

>>> rtl/core/pcm_downmix_to_stereo.sv
// Top level of the multichannel PCM to stereo downmix block.
//
// Usage:
//   Input channel: drive one frame of eight sign-extended channel samples on
//   in_data_i and raise start; the word is taken at every rising edge with
//   start high and busy low. busy stays low, so a new frame may enter on
//   every cycle.
//   Result channel: result_valid_o is high for exactly one cycle with the
//   stereo word on result_o; the receiver must take it then, it cannot stall.
//   The result passes through the registered normalize, mix and gain stages;
//   throughput is one frame per cycle, set by the fully pipelined
//   multiply chain (normalize, mix, attenuate, gain), at most one multiplier
//   deep per stage.
//   Configuration: APB-style, pready always high; sample_format at byte 0,
//   channel_layout at byte 4, gain at byte 8. Write only while no frame is
//   in flight.
//   Reset: rst_ni clears all valid bits and loads 16 bit samples, stereo
//   layout and unity gain; frames in flight are dropped.
`include "assert_macros.svh"

module pcm_downmix_to_stereo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  pdm_pkg::pdm_in_t            in_data_i,
  output logic                        result_valid_o,
  output pdm_pkg::pdm_out_t           result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pdm_pkg::AddrW-1:0]   paddr,
  input  logic [pdm_pkg::DataW-1:0]   pwdata,
  output logic [pdm_pkg::DataW-1:0]   prdata,
  output logic                        pready
);
  import pdm_pkg::*;

  pdm_cfg_t                                cfg;
  logic                                    accept;
  logic                                    norm_valid;
  logic [MaxChannels-1:0][NormW-1:0]       norm;
  logic                                    mix_valid;
  logic [NumSides-1:0][MixW-1:0]           mixed;

  // The pipeline never stalls, so the block never holds off a word.
  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;

  pdm_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  // Stages 1 to 3: sign-extend, partial products by the reciprocal, round.
  pdm_norm u_norm (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (accept),
    .word_i          (in_data_i),
    .sample_format_i (cfg.sample_format),
    .valid_o         (norm_valid),
    .norm_o          (norm)
  );

  // Stages 4 to 7: layout routing, weighted sum, attenuation.
  pdm_mix u_mix (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (norm_valid),
    .norm_i           (norm),
    .channel_layout_i (cfg.channel_layout),
    .valid_o          (mix_valid),
    .mixed_o          (mixed)
  );

  // Stages 8 and 9: gain, rounding and saturation into the output register.
  pdm_gain u_gain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (mix_valid),
    .mixed_i  (mixed),
    .gain_i   (cfg.gain),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

  `PDM_ASSERT(ResultFollowsWord, result_valid_o |-> $past(accept, PipeLatency), "result without an accepted word")

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the multichannel PCM to stereo downmix block.
module tb_top;
  import pdm_pkg::*;

  // Run shape: random words after the directed table, the last stretch without
  // idling, and a hard stop far beyond the slowest legal run.
  localparam int unsigned RandomItems = 900;
  localparam int unsigned TailItems   = 150;
  localparam int unsigned IdleMax     = 17;
  localparam longint      RunLimit    = 2_000_000;

  // Layout codes outside the defined set; the block folds them like stereo.
  localparam logic [3:0] LayoutUnusedLo = 4'd10;
  localparam logic [3:0] LayoutUnusedHi = 4'd15;

  localparam logic [GainW-1:0] GainMute  = 16'd0;
  localparam logic [GainW-1:0] GainHalf  = 16'd2048;
  localparam logic [GainW-1:0] GainUnity = 16'd4096;
  localparam logic [GainW-1:0] GainMax   = 16'hFFFF;

  // Full-scale codes of each sample width, sign-extended to the lane width.
  localparam logic [31:0] S8Max     = 32'h0000_007F;
  localparam logic [31:0] S8NegMax  = 32'hFFFF_FF81;
  localparam logic [31:0] S16Max    = 32'h0000_7FFF;
  localparam logic [31:0] S16Min    = 32'hFFFF_8000;
  localparam logic [31:0] S24Max    = 32'h007F_FFFF;
  localparam logic [31:0] S24Min    = 32'hFF80_0000;
  localparam logic [31:0] S32Max    = 32'h7FFF_FFFF;
  localparam logic [31:0] S32Min    = 32'h8000_0000;

  // Mix coefficients in Q.30, held as signed 64-bit so products stay signed.
  localparam longint UnityQ30  = 64'sd1073741824;
  localparam longint HalfQ30   = 64'sd536870912;
  localparam longint SurrGain  = longint'(SurrQ30);
  localparam longint Attn4Gain = longint'(Attn4Q30);
  localparam longint Attn5Gain = longint'(Attn5Q30);

  // Lane 0 is the most significant slice, matching ch0 in the frame struct.
  typedef logic [0:MaxChannels-1][31:0] frame_lanes_t;

  typedef struct {
    pdm_cfg_t cfg;
    pdm_in_t  frame;
    bit       typed;
    pdm_out_t due;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  pdm_in_t           in_word;
  logic              result_valid_o;
  pdm_out_t          result_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  // Shadow of the register file and the stereo words still owed by the block.
  pdm_cfg_t  cur_cfg;
  pdm_out_t  expected_stereo_q[$];
  int        mismatch_count = 0;
  stim_row_t rows[$];

  pcm_downmix_to_stereo uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_data_i      (in_word),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Downmix predictor
  // ---------------------------------------------------------------------------

  // Round half up of v / 2^s; the arithmetic shift gives the floor.
  function automatic longint round_q(longint v, int unsigned s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // Sign-extend the low bits of a lane and scale by the rounded reciprocal of
  // full scale, giving Q2.30.
  function automatic longint norm_q30(logic [31:0] raw, logic [1:0] fmt);
    int unsigned       w;
    longint unsigned   mask;
    longint unsigned   span;
    longint unsigned   recip;
    longint            x;
    w = 8 * (int'(fmt) + 1);
    mask = (64'd1 << w) - 64'd1;
    span = (64'd1 << (w - 1)) - 64'd1;
    recip = ((64'd1 << 62) + span / 64'd2) / span;
    x = longint'(64'(raw) & mask);
    if (raw[w-1]) x = x - (longint'(1) << w);
    return round_q(x * longint'(recip), 32);
  endfunction

  // Front plus half rear, then scale by 1/1.5 (quad and 4.1).
  function automatic longint rear_fold(longint f, longint r);
    longint m;
    m = round_q(f * UnityQ30 + r * HalfQ30, 30);
    return round_q(m * Attn4Gain, 30);
  endfunction

  // Front plus half center plus 0.7071 rear, then attenuate (5.1 and 7.1).
  function automatic longint center_rear_fold(longint f, longint c, longint r);
    longint m;
    m = round_q(f * UnityQ30 + c * HalfQ30 + r * SurrGain, 30);
    return round_q(m * Attn5Gain, 30);
  endfunction

  // As above with rear and side averaged; the sum is kept at Q.61 so the
  // average is exact before the single rounding.
  function automatic longint surround_fold(longint f, longint c, longint r,
                                           longint s);
    longint m;
    m = round_q(f * (2 * UnityQ30) + c * (2 * HalfQ30) + (r + s) * SurrGain, 31);
    return round_q(m * Attn5Gain, 30);
  endfunction

  function automatic logic signed [OutW-1:0] gain_and_clip(longint m,
                                                          logic [GainW-1:0] g);
    longint y;
    y = round_q(m * longint'(g), 19);
    if (y > longint'(OutMax)) y = OutMax;
    if (y < longint'(OutMin)) y = OutMin;
    return OutW'(y);
  endfunction

  function automatic pdm_out_t downmix_frame(pdm_in_t frame, pdm_cfg_t cfg);
    frame_lanes_t lanes;
    longint       nq [MaxChannels];
    longint       mix_l;
    longint       mix_r;
    pdm_out_t     word;
    lanes = frame;
    for (int i = 0; i < MaxChannels; i++) nq[i] = norm_q30(lanes[i], cfg.sample_format);
    case (cfg.channel_layout)
      LayoutMono: begin
        mix_l = nq[0];
        mix_r = nq[0];
      end
      LayoutQuad: begin
        mix_l = rear_fold(nq[0], nq[2]);
        mix_r = rear_fold(nq[1], nq[3]);
      end
      Layout41: begin
        mix_l = rear_fold(nq[0], nq[3]);
        mix_r = rear_fold(nq[1], nq[4]);
      end
      Layout51, Layout71: begin
        mix_l = center_rear_fold(nq[0], nq[2], nq[4]);
        mix_r = center_rear_fold(nq[1], nq[2], nq[5]);
      end
      Layout71Surr: begin
        mix_l = surround_fold(nq[0], nq[2], nq[4], nq[6]);
        mix_r = surround_fold(nq[1], nq[2], nq[5], nq[7]);
      end
      default: begin
        mix_l = nq[0];
        mix_r = nq[1];
      end
    endcase
    word.out_left  = gain_and_clip(mix_l, cfg.gain);
    word.out_right = gain_and_clip(mix_r, cfg.gain);
    return word;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic stim_row_t stim_row(logic [1:0] fmt, logic [3:0] lay,
                                         logic [GainW-1:0] g, frame_lanes_t lanes,
                                         bit typed, int l, int r);
    stim_row_t row;
    row.cfg.sample_format  = fmt;
    row.cfg.channel_layout = lay;
    row.cfg.gain           = g;
    row.frame              = lanes;
    row.typed              = typed;
    row.due.out_left       = OutW'(l);
    row.due.out_right      = OutW'(r);
    return row;
  endfunction

  function automatic logic [31:0] sample_max(int unsigned w);
    return 32'((64'd1 << (w - 1)) - 64'd1);
  endfunction

  function automatic logic [31:0] sample_min(int unsigned w);
    return 32'(-(longint'(1) << (w - 1)));
  endfunction

  // Four picks in ten are raw 32-bit noise so the bits above the sample width toggle too;
  // the rest are in-range values, extremes, small values and silence.
  function automatic logic [31:0] random_sample(int unsigned w);
    int unsigned pick;
    logic [31:0] tmp;
    pick = $urandom_range(0, 9);
    tmp = $urandom;
    if (pick < 4) return tmp;
    if (pick < 6) return 32'($signed(tmp << (32 - w)) >>> (32 - w));
    if (pick == 6) return sample_max(w);
    if (pick == 7) return sample_min(w);
    if (pick == 8) return 32'(int'($urandom_range(0, 16)) - 8);
    return 32'd0;
  endfunction

  function automatic pdm_in_t random_frame(logic [1:0] fmt);
    frame_lanes_t lanes;
    int unsigned  w;
    int unsigned  shape;
    w = 8 * (int'(fmt) + 1);
    shape = $urandom_range(0, 7);
    for (int i = 0; i < MaxChannels; i++) lanes[i] = random_sample(w);
    // Whole-frame extremes stress every fold at full scale.
    if (shape == 0) lanes = {MaxChannels{sample_max(w)}};
    if (shape == 1) lanes = {MaxChannels{sample_min(w)}};
    if (shape == 2) lanes = {(MaxChannels / 2){sample_max(w), sample_min(w)}};
    return lanes;
  endfunction

  function automatic pdm_cfg_t random_config();
    pdm_cfg_t cfg;
    cfg.sample_format = 2'($urandom_range(FmtW8, FmtW32));
    if ($urandom_range(0, 7) == 0)
      cfg.channel_layout = 4'($urandom_range(LayoutUnusedLo, LayoutUnusedHi));
    else
      cfg.channel_layout = 4'($urandom_range(LayoutMono, Layout71Surr));
    case ($urandom_range(0, 5))
      0:       cfg.gain = GainMute;
      1:       cfg.gain = GainMax;
      2:       cfg.gain = GainUnity;
      default: cfg.gain = GainW'($urandom);
    endcase
    return cfg;
  endfunction

  // ---------------------------------------------------------------------------
  // Bus tasks
  // ---------------------------------------------------------------------------

  // Present one frame and hold it until the accepting edge, then log the
  // stereo word it owes. start stays high so the next word can follow at once.
  task automatic send_word(input pdm_in_t word, input pdm_out_t due);
    start   <= 1'b1;
    in_word <= word;
    do @(posedge clk_i); while (busy);
    expected_stereo_q.push_back(due);
  endtask

  // Drop start and wait for every owed word to come back.
  task automatic hold_until_drained();
    start <= 1'b0;
    while (expected_stereo_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the register takes the data at the edge
  // that ends the access cycle.
  task automatic cfg_write(input logic [1:0] idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegSampleFormat:  cur_cfg.sample_format  = value[1:0];
      RegChannelLayout: cur_cfg.channel_layout = value[3:0];
      RegGain:          cur_cfg.gain           = value[GainW-1:0];
      default: ;
    endcase
  endtask

  // Reprogram only once the pipe is empty; touch just the fields that change.
  task automatic apply_config(input pdm_cfg_t next);
    hold_until_drained();
    if (next.sample_format != cur_cfg.sample_format)
      cfg_write(RegSampleFormat, DataW'(next.sample_format));
    if (next.channel_layout != cur_cfg.channel_layout)
      cfg_write(RegChannelLayout, DataW'(next.channel_layout));
    if (next.gain != cur_cfg.gain)
      cfg_write(RegGain, DataW'(next.gain));
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobed word must match the oldest owed word.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    pdm_out_t due;
    if (rst_ni && result_valid_o) begin
      if (expected_stereo_q.size() == 0) begin
        $error("stereo word with nothing owed: out_left %0d out_right %0d",
               result_o.out_left, result_o.out_right);
        mismatch_count++;
      end else begin
        due = expected_stereo_q.pop_front();
        if (result_o.out_left !== due.out_left) begin
          $error("out_left: expected %0d, got %0d", due.out_left, result_o.out_left);
          mismatch_count++;
        end
        if (result_o.out_right !== due.out_right) begin
          $error("out_right: expected %0d, got %0d", due.out_right, result_o.out_right);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    pdm_cfg_t    next_cfg;
    int unsigned sent;
    int unsigned phase;
    int unsigned phase_len;
    bit          quiet;
    bit          tail;
    pdm_in_t     word;

    // Drive every input to a known value before the first edge.
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    in_word <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    cur_cfg.sample_format  = SampleFormatRst;
    cur_cfg.channel_layout = ChannelLayoutRst;
    cur_cfg.gain           = GainRst;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Typed results are the ones readable by eye: silence,
    // full scale landing exactly on half scale, clipping and muting.
    rows.push_back(stim_row(FmtW16, LayoutStereo, GainUnity, {8{32'd0}}, 1, 0, 0));
    rows.push_back(stim_row(FmtW16, LayoutStereo, GainUnity,
                            {S16Max, S16Min, {6{32'h5A5A_5A5A}}}, 1, 8388607, -8388608));
    rows.push_back(stim_row(FmtW16, LayoutStereo, GainMax,
                            {32'd1, 32'hFFFF_FFFF, {6{32'd0}}}, 0, 0, 0));
    rows.push_back(stim_row(FmtW8, LayoutStereo, GainHalf,
                            {S8Max, S8NegMax, {6{32'd0}}}, 1, 4194304, -4194304));
    // Bits above the sample width must be ignored.
    rows.push_back(stim_row(FmtW8, LayoutStereo, GainHalf,
                            {32'hFFFF_FF7F, 32'h1234_5600, {6{32'hFFFF_FFFF}}}, 1, 4194304, 0));
    rows.push_back(stim_row(FmtW8, LayoutStereo, GainUnity,
                            {32'h0000_0080, 32'hABCD_EF7F, {6{32'd0}}}, 1, -8388608, 8388607));
    rows.push_back(stim_row(FmtW24, LayoutMono, GainHalf,
                            {S24Max, S32Max, {6{32'd0}}}, 1, 4194304, 4194304));
    rows.push_back(stim_row(FmtW24, LayoutMono, GainUnity,
                            {S24Min, {7{32'd0}}}, 1, -8388608, -8388608));
    rows.push_back(stim_row(FmtW32, LayoutStereo, GainHalf,
                            {S32Max, S32Min, {6{32'd0}}}, 1, 4194304, -4194304));
    // Unused layout codes pass ch0 and ch1 straight through.
    rows.push_back(stim_row(FmtW32, LayoutUnusedHi, GainHalf,
                            {S32Max, S32Min, {6{32'd0}}}, 1, 4194304, -4194304));
    rows.push_back(stim_row(FmtW32, LayoutUnusedLo, GainMute, {8{S32Max}}, 1, 0, 0));
    rows.push_back(stim_row(FmtW16, LayoutQuad, GainUnity, {8{S16Max}}, 0, 0, 0));
    rows.push_back(stim_row(FmtW16, LayoutQuad, GainUnity,
                            {S16Max, S16Min, S16Min, S16Max, {4{32'd0}}}, 0, 0, 0));
    rows.push_back(stim_row(FmtW16, Layout21, GainUnity,
                            {32'h0000_4000, 32'hFFFF_C000, {6{S16Max}}}, 0, 0, 0));
    rows.push_back(stim_row(FmtW16, Layout31, GainMax,
                            {32'd3, 32'hFFFF_FFFD, {6{S16Min}}}, 0, 0, 0));
    rows.push_back(stim_row(FmtW16, Layout41, GainUnity,
                            {S16Max, S16Max, S16Min, S16Max, S16Max, {3{S16Min}}}, 0, 0, 0));
    rows.push_back(stim_row(FmtW16, LayoutLcrs, GainUnity,
                            {S16Min, 32'd100, {6{S16Max}}}, 0, 0, 0));
    rows.push_back(stim_row(FmtW16, Layout51, GainUnity, {8{S16Max}}, 0, 0, 0));
    rows.push_back(stim_row(FmtW16, Layout51, GainUnity, {8{S16Min}}, 0, 0, 0));
    // 7.1 drops the side pair, so garbage there must not leak.
    rows.push_back(stim_row(FmtW16, Layout71, GainMax,
                            {32'd7, 32'hFFFF_FFF9, 32'd1000, 32'd0, S16Max, S16Min,
                             32'h1234_5678, 32'h8765_4321}, 0, 0, 0));
    rows.push_back(stim_row(FmtW32, Layout71Surr, GainUnity, {8{S32Max}}, 0, 0, 0));
    rows.push_back(stim_row(FmtW32, Layout71Surr, GainMax, {8{S32Min}}, 0, 0, 0));
    rows.push_back(stim_row(FmtW24, Layout71Surr, GainUnity,
                            {S24Max, S24Min, 32'd0, S24Max, S24Min, S24Max, S24Max, S24Min},
                            0, 0, 0));
    rows.push_back(stim_row(FmtW16, LayoutStereo, GainMax,
                            {S16Max, S16Min, {6{32'd0}}}, 1, 8388607, -8388608));
    rows.push_back(stim_row(FmtW24, Layout51, 16'd12345,
                            {S24Max, 32'h0012_3456, S24Min, 32'hFFF0_0001, 32'd77,
                             S24Max, 32'd0, 32'd0}, 0, 0, 0));

    foreach (rows[i]) begin
      if (rows[i].cfg != cur_cfg) apply_config(rows[i].cfg);
      send_word(rows[i].frame,
                rows[i].typed ? rows[i].due : downmix_frame(rows[i].frame, cur_cfg));
    end

    // Random phases: each phase before the closing stretch picks a fresh
    // setting, then streams frames with idle bursts, except in quiet phases
    // and in the closing stretch, which keeps the last setting.
    sent = 0;
    phase = 0;
    while (sent < RandomItems) begin
      if (sent < RandomItems - TailItems) begin
        next_cfg = random_config();
        apply_config(next_cfg);
      end
      phase_len = $urandom_range(40, 90);
      quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < phase_len && sent < RandomItems; k++) begin
        tail = (sent >= RandomItems - TailItems);
        if (!quiet && !tail && $urandom_range(0, 7) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, IdleMax)) @(posedge clk_i);
        end
        // Hold off mid-phase until the pipe has emptied, once for sure.
        if ((phase == 0 && k == phase_len / 2) || (!tail && $urandom_range(0, 199) == 0))
          hold_until_drained();
        word = random_frame(cur_cfg.sample_format);
        send_word(word, downmix_frame(word, cur_cfg));
        sent++;
      end
      phase++;
    end

    // Flush, then watch a little longer for stray words.
    hold_until_drained();
    repeat (PipeLatency + 4) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #RunLimit;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> pcm_downmix_to_stereo.f
+incdir+rtl/core
rtl/core/pdm_pkg.sv
rtl/core/pdm_regs.sv
rtl/core/pdm_norm.sv
rtl/core/pdm_mix.sv
rtl/core/pdm_gain.sv
rtl/core/pcm_downmix_to_stereo.sv
verif/tb_top.sv
